// ----- src/bsct_pkg.sv -----
// Shared types, constants and helpers for the beam switch command timer.
// Used by every module of the block; depends on nothing.
package bsct_pkg;

  // Field widths
  localparam int unsigned CfgW      = 24;
  localparam int unsigned GapW      = 16;
  localparam int unsigned TimeW     = 36;
  localparam int unsigned AddrW     = 7;
  localparam int unsigned PayloadW  = 6;
  localparam int unsigned SpiW      = AddrW + PayloadW;
  localparam int unsigned CfgIndexW = 2;

  // Configuration register indexes
  localparam logic [CfgIndexW-1:0] RegFrameSamples  = 2'd0;
  localparam logic [CfgIndexW-1:0] RegSlotSamples   = 2'd1;
  localparam logic [CfgIndexW-1:0] RegSymbolSamples = 2'd2;
  localparam logic [CfgIndexW-1:0] RegMinGapSamples = 2'd3;

  // Reset values of the configuration registers
  localparam logic [CfgW-1:0] FrameSamplesRst  = 24'd307200;
  localparam logic [CfgW-1:0] SlotSamplesRst   = 24'd15360;
  localparam logic [CfgW-1:0] SymbolSamplesRst = 24'd1097;
  localparam logic [GapW-1:0] MinGapSamplesRst = 16'd102;

  // Beam table register addresses
  localparam logic [AddrW-1:0] TxGainAddr  = 7'h58;
  localparam logic [AddrW-1:0] TxPhaseAddr = 7'h78;
  localparam logic [AddrW-1:0] RxGainAddr  = 7'h54;
  localparam logic [AddrW-1:0] RxPhaseAddr = 7'h70;

  typedef struct packed {
    logic [CfgW-1:0] frame_samples;
    logic [CfgW-1:0] slot_samples;
    logic [CfgW-1:0] symbol_samples;
    logic [GapW-1:0] min_gap_samples;
  } bsct_cfg_t;

  // Per-command control carried alongside the timestamp
  typedef struct packed {
    logic                rx_direction;
    logic [PayloadW-1:0] payload;
    logic                first_of_batch;
  } bsct_cmd_t;

  // Register address for one word of the pair
  function automatic logic [AddrW-1:0] spi_addr(input logic rx, input logic phase);
    logic [AddrW-1:0] addr;
    unique case ({rx, phase})
      2'b00:   addr = TxGainAddr;
      2'b01:   addr = TxPhaseAddr;
      2'b10:   addr = RxGainAddr;
      default: addr = RxPhaseAddr;
    endcase
    return addr;
  endfunction

endpackage

// ----- src/beam_switch_command_timer.sv -----
// A command passes the input, product, sum and output registers and leaves as a gain
// word, then a phase word; the output takes a new command once both words are taken.
// The timestamp pipeline (input, product, sum) takes a command every cycle unless stalled.
// Reset: asynchronous, active low; clears all valid flags and the previous timestamp,
// and loads the configuration registers with their default sample counts.
module beam_switch_command_timer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [bsct_pkg::CfgIndexW-1:0]   cfg_index_i,
  input  logic [bsct_pkg::CfgW-1:0]        cfg_wdata_i,
  // command words
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [9:0]                       frame_number_i,
  input  logic [7:0]                       slot_number_i,
  input  logic [3:0]                       symbol_number_i,
  input  logic                             rx_direction_i,
  input  logic [7:0]                       beam_number_i,
  input  logic                             first_of_batch_i,
  // SPI result words
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [bsct_pkg::SpiW-1:0]        spi_word_o,
  output logic                             phase_word_o,
  output logic [bsct_pkg::TimeW-1:0]       sample_time_o,
  output logic                             collision_o,
  output logic                             last_word_o
);

  bsct_pkg::bsct_cfg_t          cfg;
  bsct_pkg::bsct_cmd_t          cmd_in;
  bsct_pkg::bsct_cmd_t          t_cmd;
  logic                         in_ready;
  logic                         t_valid;
  logic                         t_ready;
  logic [bsct_pkg::TimeW-1:0]   t_time;

  // Beam payload is (beam - 1) mod 64; beam zero wraps to 63
  assign cmd_in.rx_direction   = rx_direction_i;
  assign cmd_in.payload        = beam_number_i[bsct_pkg::PayloadW-1:0] - 6'd1;
  assign cmd_in.first_of_batch = first_of_batch_i;

  assign in_stall_o = !in_ready;

  bsct_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bsct_time u_time (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready),
    .frame_number_i  (frame_number_i),
    .slot_number_i   (slot_number_i),
    .symbol_number_i (symbol_number_i),
    .cmd_i           (cmd_in),
    .t_valid_o       (t_valid),
    .t_ready_i       (t_ready),
    .t_time_o        (t_time),
    .t_cmd_o         (t_cmd)
  );

  bsct_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .min_gap_i     (cfg.min_gap_samples),
    .t_valid_i     (t_valid),
    .t_ready_o     (t_ready),
    .t_time_i      (t_time),
    .t_cmd_i       (t_cmd),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .spi_word_o    (spi_word_o),
    .phase_word_o  (phase_word_o),
    .sample_time_o (sample_time_o),
    .collision_o   (collision_o),
    .last_word_o   (last_word_o)
  );

endmodule

// ----- src/bsct_cfg.sv -----
// Configuration registers of the beam switch command timer.
// Depends on bsct_pkg.
module bsct_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bsct_pkg::CfgIndexW-1:0]   cfg_index_i,
  input  logic [bsct_pkg::CfgW-1:0]        cfg_wdata_i,
  output bsct_pkg::bsct_cfg_t              cfg_o
);

  bsct_pkg::bsct_cfg_t cfg_q;

  // Register file, written by index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_samples   <= bsct_pkg::FrameSamplesRst;
      cfg_q.slot_samples    <= bsct_pkg::SlotSamplesRst;
      cfg_q.symbol_samples  <= bsct_pkg::SymbolSamplesRst;
      cfg_q.min_gap_samples <= bsct_pkg::MinGapSamplesRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        bsct_pkg::RegFrameSamples:  cfg_q.frame_samples  <= cfg_wdata_i;
        bsct_pkg::RegSlotSamples:   cfg_q.slot_samples   <= cfg_wdata_i;
        bsct_pkg::RegSymbolSamples: cfg_q.symbol_samples <= cfg_wdata_i;
        bsct_pkg::RegMinGapSamples:
          cfg_q.min_gap_samples <= cfg_wdata_i[bsct_pkg::GapW-1:0];
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- src/bsct_time.sv -----
// Timestamp pipeline: input register, product register, sum register.
// Depends on bsct_pkg.
module bsct_time (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bsct_pkg::bsct_cfg_t           cfg_i,
  // command word in
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [9:0]                    frame_number_i,
  input  logic [7:0]                    slot_number_i,
  input  logic [3:0]                    symbol_number_i,
  input  bsct_pkg::bsct_cmd_t           cmd_i,
  // timestamped command out
  output logic                          t_valid_o,
  input  logic                          t_ready_i,
  output logic [bsct_pkg::TimeW-1:0]    t_time_o,
  output bsct_pkg::bsct_cmd_t           t_cmd_o
);

  // Stage 0: captured command
  logic                valid0_q;
  logic [9:0]          frame0_q;
  logic [7:0]          slot0_q;
  logic [3:0]          sym0_q;
  bsct_pkg::bsct_cmd_t cmd0_q;
  // Stage 1: partial products
  logic                valid1_q;
  logic [33:0]         pfrm1_q;
  logic [31:0]         pslt1_q;
  logic [27:0]         psym1_q;
  bsct_pkg::bsct_cmd_t cmd1_q;
  // Stage 2: timestamp
  logic                          valid2_q;
  logic [bsct_pkg::TimeW-1:0]    time2_q;
  bsct_pkg::bsct_cmd_t           cmd2_q;

  logic ready0, ready1, ready2;
  logic [33:0] pfrm1_d;
  logic [31:0] pslt1_d;
  logic [27:0] psym1_d;
  logic [bsct_pkg::TimeW-1:0] time2_d;

  assign ready2 = !valid2_q || t_ready_i;
  assign ready1 = !valid1_q || ready2;
  assign ready0 = !valid0_q || ready1;
  assign in_ready_o = ready0;

  // Three independent multiplies
  assign pfrm1_d = {24'd0, frame0_q} * {10'd0, cfg_i.frame_samples};
  assign pslt1_d = {24'd0, slot0_q} * {8'd0, cfg_i.slot_samples};
  assign psym1_d = {24'd0, sym0_q} * {4'd0, cfg_i.symbol_samples};

  // Sum never exceeds 36 bits for any operand values
  assign time2_d = {2'd0, pfrm1_q} + {4'd0, pslt1_q} + {8'd0, psym1_q};

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid0_q <= 1'b0;
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else begin
      if (ready0) valid0_q <= in_valid_i;
      if (ready1) valid1_q <= valid0_q;
      if (ready2) valid2_q <= valid1_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && ready0) begin
      frame0_q <= frame_number_i;
      slot0_q  <= slot_number_i;
      sym0_q   <= symbol_number_i;
      cmd0_q   <= cmd_i;
    end
    if (valid0_q && ready1) begin
      pfrm1_q <= pfrm1_d;
      pslt1_q <= pslt1_d;
      psym1_q <= psym1_d;
      cmd1_q  <= cmd0_q;
    end
    if (valid1_q && ready2) begin
      time2_q <= time2_d;
      cmd2_q  <= cmd1_q;
    end
  end

  assign t_valid_o = valid2_q;
  assign t_time_o  = time2_q;
  assign t_cmd_o   = cmd2_q;

  // A stalled timestamp holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid2_q && !t_ready_i |=> valid2_q && $stable(time2_q))
    else $error("bsct_time: stalled timestamp changed");

endmodule

// ----- src/bsct_out.sv -----
// Gap check against the previous timestamp and the two-word SPI output register.
// Depends on bsct_pkg.
module bsct_out (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [bsct_pkg::GapW-1:0]        min_gap_i,
  // timestamped command in
  input  logic                             t_valid_i,
  output logic                             t_ready_o,
  input  logic [bsct_pkg::TimeW-1:0]       t_time_i,
  input  bsct_pkg::bsct_cmd_t              t_cmd_i,
  // result words
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [bsct_pkg::SpiW-1:0]        spi_word_o,
  output logic                             phase_word_o,
  output logic [bsct_pkg::TimeW-1:0]       sample_time_o,
  output logic                             collision_o,
  output logic                             last_word_o
);

  logic                             valid_q;
  logic                             word_q;     // 0 gain word, 1 phase word
  logic [bsct_pkg::TimeW-1:0]       prev_q;
  logic [bsct_pkg::TimeW-1:0]       time_q;
  logic                             coll_q;
  logic                             rx_q;
  logic [bsct_pkg::PayloadW-1:0]    payload_q;

  logic                             out_take;
  logic                             load;
  logic [bsct_pkg::TimeW:0]         limit;
  logic                             coll_d;

  assign out_take  = valid_q && !out_stall_i;
  assign t_ready_o = !valid_q || (word_q && out_take);
  assign load      = t_valid_i && t_ready_o;

  // Gap below minimum, or going backwards, is a collision unless a batch starts: t < prev + min
  assign limit  = {1'b0, prev_q} + {{(bsct_pkg::TimeW + 1 - bsct_pkg::GapW){1'b0}}, min_gap_i};
  assign coll_d = !t_cmd_i.first_of_batch && ({1'b0, t_time_i} < limit);

  // Control and previous timestamp
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      word_q  <= 1'b0;
      prev_q  <= '0;
    end else if (load) begin
      valid_q <= 1'b1;
      word_q  <= 1'b0;
      prev_q  <= t_time_i;
    end else if (out_take) begin
      if (word_q) begin
        valid_q <= 1'b0;
        word_q  <= 1'b0;
      end else begin
        word_q <= 1'b1;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      time_q    <= t_time_i;
      coll_q    <= coll_d;
      rx_q      <= t_cmd_i.rx_direction;
      payload_q <= t_cmd_i.payload;
    end
  end

  assign out_valid_o   = valid_q;
  assign spi_word_o    = {bsct_pkg::spi_addr(rx_q, word_q), payload_q};
  assign phase_word_o  = word_q;
  assign sample_time_o = time_q;
  assign collision_o   = coll_q;
  assign last_word_o   = word_q;

  // Phase word flag only while a command is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_q |-> !word_q)
    else $error("bsct_out: phase word flag without a command");

  // Taking the gain word leaves the phase word of the same command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && !word_q |=> valid_q && word_q && $stable(time_q))
    else $error("bsct_out: phase word did not follow gain word");

  // A new command only enters once both words of the last one are gone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && valid_q |-> word_q && !out_stall_i)
    else $error("bsct_out: command overwritten before delivery");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for beam_switch_command_timer: directed commands, then random
// command batches under several register settings. Depends on bsct_pkg and the block's RTL.
module testbench;

  typedef logic [bsct_pkg::CfgW-1:0]  reg_value_t;
  typedef logic [bsct_pkg::TimeW-1:0] stamp_t;
  typedef logic [bsct_pkg::SpiW-1:0]  spi_t;

  typedef struct packed {
    logic [9:0] frame;
    logic [7:0] slot;
    logic [3:0] symbol;
    logic       rx;
    logic [7:0] beam;
    logic       first;
  } command_t;

  typedef struct packed {
    spi_t   spi;
    logic   phase;
    stamp_t stamp;
    logic   coll;
    logic   last;
  } beam_word_t;

  typedef enum logic {RowCommand, RowRegWrite} row_kind_e;

  typedef struct {
    row_kind_e                      kind;
    logic [bsct_pkg::CfgIndexW-1:0] reg_idx;
    reg_value_t                     reg_val;
    command_t                       cmd;
    bit                             literal;
    beam_word_t                     lit_gain;
    beam_word_t                     lit_phase;
  } script_row_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [bsct_pkg::CfgIndexW-1:0] cfg_index_i;
  reg_value_t                     cfg_wdata_i;
  logic                           in_valid_i;
  logic                           in_stall_o;
  logic [9:0]                     frame_number_i;
  logic [7:0]                     slot_number_i;
  logic [3:0]                     symbol_number_i;
  logic                           rx_direction_i;
  logic [7:0]                     beam_number_i;
  logic                           first_of_batch_i;
  logic                           out_valid_o;
  logic                           out_stall_i;
  spi_t                           spi_word_o;
  logic                           phase_word_o;
  stamp_t                         sample_time_o;
  logic                           collision_o;
  logic                           last_word_o;

  // Predictor copy of the registers and the previous timestamp
  reg_value_t                 frame_len;
  reg_value_t                 slot_len;
  reg_value_t                 symbol_len;
  logic [bsct_pkg::GapW-1:0]  min_spacing;
  stamp_t                     last_stamp;

  beam_word_t pending_words[$];
  int         mismatches;
  bit         idling;

  beam_switch_command_timer dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .frame_number_i   (frame_number_i),
    .slot_number_i    (slot_number_i),
    .symbol_number_i  (symbol_number_i),
    .rx_direction_i   (rx_direction_i),
    .beam_number_i    (beam_number_i),
    .first_of_batch_i (first_of_batch_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .spi_word_o       (spi_word_o),
    .phase_word_o     (phase_word_o),
    .sample_time_o    (sample_time_o),
    .collision_o      (collision_o),
    .last_word_o      (last_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Gain and phase words for one command; advances the previous timestamp
  function automatic void predict_word_pair(input command_t c, output beam_word_t gain,
                                            output beam_word_t phase);
    logic [63:0]                   sum;
    stamp_t                        stamp;
    stamp_t                        gap_floor;
    logic                          coll;
    logic [7:0]                    beam_less;
    logic [bsct_pkg::PayloadW-1:0] payload;
    sum = 64'(c.frame) * 64'(frame_len) + 64'(c.slot) * 64'(slot_len)
        + 64'(c.symbol) * 64'(symbol_len);
    stamp = sum[bsct_pkg::TimeW-1:0];
    gap_floor = stamp_t'(min_spacing);
    // a batch start is never flagged; any other backward step always is
    coll = !c.first && (stamp < last_stamp || (stamp - last_stamp) < gap_floor);
    last_stamp = stamp;
    beam_less = c.beam - 8'd1;
    payload = beam_less[bsct_pkg::PayloadW-1:0];
    gain  = '{spi: {c.rx ? bsct_pkg::RxGainAddr : bsct_pkg::TxGainAddr, payload},
              phase: 1'b0, stamp: stamp, coll: coll, last: 1'b0};
    phase = '{spi: {c.rx ? bsct_pkg::RxPhaseAddr : bsct_pkg::TxPhaseAddr, payload},
              phase: 1'b1, stamp: stamp, coll: coll, last: 1'b1};
  endfunction

  function automatic script_row_t cmd_row(input int f, input int s, input int y, input int rx,
                                          input int b, input int first);
    script_row_t r;
    r = '{kind: RowCommand, reg_idx: '0, reg_val: '0, cmd: '{10'(f), 8'(s), 4'(y), 1'(rx),
          8'(b), 1'(first)}, literal: 1'b0, lit_gain: '0, lit_phase: '0};
    return r;
  endfunction

  // Command row whose words are typed in directly
  function automatic script_row_t lit_row(input int f, input int s, input int y, input int rx,
                                          input int b, input int first, input int gain_spi,
                                          input int phase_spi, input int stamp,
                                          input int coll);
    script_row_t r;
    r = cmd_row(f, s, y, rx, b, first);
    r.literal   = 1'b1;
    r.lit_gain  = '{spi_t'(gain_spi), 1'b0, stamp_t'(stamp), 1'(coll), 1'b0};
    r.lit_phase = '{spi_t'(phase_spi), 1'b1, stamp_t'(stamp), 1'(coll), 1'b1};
    return r;
  endfunction

  function automatic script_row_t reg_row(input logic [bsct_pkg::CfgIndexW-1:0] idx,
                                          input int val);
    script_row_t r;
    r = cmd_row(0, 0, 0, 0, 0, 0);
    r.kind    = RowRegWrite;
    r.reg_idx = idx;
    r.reg_val = reg_value_t'(val);
    return r;
  endfunction

  task automatic write_reg(input logic [bsct_pkg::CfgIndexW-1:0] idx, input reg_value_t val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      bsct_pkg::RegFrameSamples:  frame_len   = val;
      bsct_pkg::RegSlotSamples:   slot_len    = val;
      bsct_pkg::RegSymbolSamples: symbol_len  = val;
      bsct_pkg::RegMinGapSamples: min_spacing = val[bsct_pkg::GapW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Entered and left at a falling edge; returns once the word is taken
  task automatic send_command(input command_t c, input bit literal, input beam_word_t lit_gain,
                              input beam_word_t lit_phase);
    beam_word_t gain;
    beam_word_t phase;
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    frame_number_i   <= c.frame;
    slot_number_i    <= c.slot;
    symbol_number_i  <= c.symbol;
    rx_direction_i   <= c.rx;
    beam_number_i    <= c.beam;
    first_of_batch_i <= c.first;
    do @(posedge clk_i); while (in_stall_o);
    predict_word_pair(c, gain, phase);
    pending_words.push_back(literal ? lit_gain : gain);
    pending_words.push_back(literal ? lit_phase : phase);
    @(negedge clk_i);
  endtask

  // Let every expected word come out before touching the registers
  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Receiver stalls in random bursts, only while idling is set
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(0, 2);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Compare every taken word with the oldest expectation
  always @(posedge clk_i) begin : check_words
    beam_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_words.size() == 0) begin
        $error("unexpected word: spi_word %h sample_time %0d", spi_word_o, sample_time_o);
        mismatches++;
      end else begin
        want = pending_words.pop_front();
        if (spi_word_o !== want.spi) begin
          $error("spi_word: expected %h, got %h", want.spi, spi_word_o);
          mismatches++;
        end
        if (phase_word_o !== want.phase) begin
          $error("phase_word: expected %b, got %b", want.phase, phase_word_o);
          mismatches++;
        end
        if (sample_time_o !== want.stamp) begin
          $error("sample_time: expected %0d, got %0d", want.stamp, sample_time_o);
          mismatches++;
        end
        if (collision_o !== want.coll) begin
          $error("collision: expected %b, got %b", want.coll, collision_o);
          mismatches++;
        end
        if (last_word_o !== want.last) begin
          $error("last_word: expected %b, got %b", want.last, last_word_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    script_row_t script[$];
    command_t    c;
    beam_word_t  none;
    int          batch_left;
    int          sym;
    int          slot;
    none        = '0;
    mismatches  = 0;
    idling      = 1'b1;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = bsct_pkg::RegFrameSamples;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    out_stall_i = 1'b0;
    c           = '0;
    {frame_number_i, slot_number_i, symbol_number_i} = '0;
    {rx_direction_i, beam_number_i, first_of_batch_i} = '0;
    frame_len   = bsct_pkg::FrameSamplesRst;
    slot_len    = bsct_pkg::SlotSamplesRst;
    symbol_len  = bsct_pkg::SymbolSamplesRst;
    min_spacing = bsct_pkg::MinGapSamplesRst;
    last_stamp  = '0;

    // Directed commands, reset register values first
    script.push_back(lit_row(0, 0, 0, 0, 1, 0, 'h1600, 'h1E00, 0, 1));      // no batch start
    script.push_back(lit_row(0, 0, 1, 0, 0, 0, 'h163F, 'h1E3F, 1097, 0));   // beam zero wraps
    script.push_back(lit_row(0, 0, 1, 1, 255, 0, 'h153E, 'h1C3E, 1097, 1)); // same timestamp
    script.push_back(cmd_row(1, 0, 0, 0, 64, 1));
    script.push_back(cmd_row(0, 19, 13, 1, 128, 0));                        // goes backwards
    script.push_back(cmd_row(0, 19, 13, 0, 2, 1));
    script.push_back(cmd_row(1023, 255, 15, 1, 255, 1));                    // fields at max
    script.push_back(cmd_row(1023, 159, 13, 0, 170, 0));
    script.push_back(cmd_row(512, 85, 10, 1, 85, 0));
    // unit sample counts, zero spacing: only a backward step collides
    script.push_back(reg_row(bsct_pkg::RegFrameSamples, 1));
    script.push_back(reg_row(bsct_pkg::RegSlotSamples, 1));
    script.push_back(reg_row(bsct_pkg::RegSymbolSamples, 1));
    script.push_back(reg_row(bsct_pkg::RegMinGapSamples, 0));
    script.push_back(lit_row(5, 0, 0, 0, 33, 1, 'h1620, 'h1E20, 5, 0));
    script.push_back(lit_row(5, 0, 0, 0, 33, 0, 'h1620, 'h1E20, 5, 0));
    script.push_back(lit_row(4, 0, 0, 0, 33, 0, 'h1620, 'h1E20, 4, 1));
    // gap exactly at the minimum, then one short of it
    script.push_back(reg_row(bsct_pkg::RegMinGapSamples, 2));
    script.push_back(cmd_row(4, 2, 0, 1, 7, 0));
    script.push_back(cmd_row(4, 2, 1, 1, 7, 0));
    // every register at its maximum
    script.push_back(reg_row(bsct_pkg::RegFrameSamples, 'hFFFFFF));
    script.push_back(reg_row(bsct_pkg::RegSlotSamples, 'hFFFFFF));
    script.push_back(reg_row(bsct_pkg::RegSymbolSamples, 'hFFFFFF));
    script.push_back(reg_row(bsct_pkg::RegMinGapSamples, 'hFFFF));
    script.push_back(cmd_row(1023, 255, 15, 0, 1, 0));
    script.push_back(cmd_row(0, 0, 0, 1, 0, 0));
    script.push_back(cmd_row(0, 0, 1, 1, 0, 0));

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (script[i]) begin
      if (script[i].kind == RowRegWrite) begin
        drain();
        write_reg(script[i].reg_idx, script[i].reg_val);
      end else begin
        send_command(script[i].cmd, script[i].literal, script[i].lit_gain,
                     script[i].lit_phase);
      end
    end

    // Random phases, each under its own register setting
    for (int ph = 0; ph < 7; ph++) begin
      drain();
      case (ph)
        0: begin
          write_reg(bsct_pkg::RegFrameSamples, bsct_pkg::FrameSamplesRst);
          write_reg(bsct_pkg::RegSlotSamples, bsct_pkg::SlotSamplesRst);
          write_reg(bsct_pkg::RegSymbolSamples, bsct_pkg::SymbolSamplesRst);
          write_reg(bsct_pkg::RegMinGapSamples, reg_value_t'(bsct_pkg::MinGapSamplesRst));
        end
        1, 6: begin
          write_reg(bsct_pkg::RegFrameSamples, reg_value_t'($urandom_range(1, 3)));
          write_reg(bsct_pkg::RegSlotSamples, reg_value_t'($urandom_range(1, 3)));
          write_reg(bsct_pkg::RegSymbolSamples, reg_value_t'(1));
          write_reg(bsct_pkg::RegMinGapSamples, reg_value_t'($urandom_range(0, 4)));
        end
        2: begin
          write_reg(bsct_pkg::RegFrameSamples, 24'hFFFFFF);
          write_reg(bsct_pkg::RegSlotSamples, 24'hFFFFFF);
          write_reg(bsct_pkg::RegSymbolSamples, 24'hFFFFFF);
          write_reg(bsct_pkg::RegMinGapSamples, 24'h00FFFF);
        end
        4: begin
          write_reg(bsct_pkg::RegFrameSamples, reg_value_t'(614400));
          write_reg(bsct_pkg::RegSlotSamples, reg_value_t'(30720));
          write_reg(bsct_pkg::RegSymbolSamples, reg_value_t'(2194));
          write_reg(bsct_pkg::RegMinGapSamples, reg_value_t'($urandom_range(0, 4000)));
        end
        default: begin
          write_reg(bsct_pkg::RegFrameSamples, reg_value_t'($urandom));
          write_reg(bsct_pkg::RegSlotSamples, reg_value_t'($urandom));
          write_reg(bsct_pkg::RegSymbolSamples, reg_value_t'($urandom));
          write_reg(bsct_pkg::RegMinGapSamples, reg_value_t'($urandom));
        end
      endcase
      // no idle gaps or receiver stalls in phase 2 and in the last phase
      idling = (ph != 2 && ph != 6);
      batch_left = 0;
      slot = 0;
      sym = 0;
      for (int n = 0; n < 150; n++) begin
        c.rx   = 1'($urandom);
        c.beam = 8'($urandom);
        if ($urandom_range(0, 3) == 0) begin
          // noise: any field value, batch flag at random
          c.frame  = 10'($urandom);
          c.slot   = 8'($urandom);
          c.symbol = 4'($urandom);
          c.first  = 1'($urandom);
          batch_left = 0;
        end else begin
          if (batch_left == 0) begin
            // new batch, symbols counting up and rolling into the next slot
            c.frame    = 10'($urandom_range(0, 1023));
            slot       = $urandom_range(0, 159);
            sym        = $urandom_range(0, 3);
            batch_left = $urandom_range(2, 8);
            c.first    = 1'b1;
          end else begin
            sym += $urandom_range(0, 3);
            if (sym > 13) begin
              sym -= 14;
              slot = (slot + 1) % 160;
            end
            c.first = 1'b0;
          end
          batch_left--;
          c.slot   = 8'(slot);
          c.symbol = 4'(sym);
        end
        send_command(c, 1'b0, none, none);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- beam_switch_command_timer.f -----
src/bsct_pkg.sv
src/bsct_cfg.sv
src/bsct_time.sv
src/bsct_out.sv
src/beam_switch_command_timer.sv
tb/testbench.sv
